// ===== rtl/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// rws_pkg
// Shared widths, codes and the sequencer state type of the region scroll block.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int PIX_W   = 24;   // rgb pixel word
  localparam int COORD_W = 9;    // pixel_x / pixel_y field width
  localparam int CFG_W   = 10;   // widest configuration register
  localparam int FUNC_W  = 2;
  localparam int DIR_W   = 2;
  localparam int IDX_W   = 3;    // configuration register index

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // function codes of an input word
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCROLL = 2'd2;

  // scroll directions
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_X_START      = 3'd2;
  localparam logic [IDX_W-1:0] REG_X_END        = 3'd3;
  localparam logic [IDX_W-1:0] REG_Y_START      = 3'd4;
  localparam logic [IDX_W-1:0] REG_Y_END        = 3'd5;
  localparam logic [IDX_W-1:0] REG_DIRECTION    = 3'd6;

  // configuration reset values
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 10'd512;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 10'd512;
  localparam logic [CFG_W-1:0] RST_X_START      = 10'd0;
  localparam logic [CFG_W-1:0] RST_X_END        = 10'd512;
  localparam logic [CFG_W-1:0] RST_Y_START      = 10'd0;
  localparam logic [CFG_W-1:0] RST_Y_END        = 10'd512;
  localparam logic [DIR_W-1:0] RST_DIRECTION    = DIR_LEFT;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_SCR_RD,
    ST_SCR_TAIL,
    ST_SCR_WRAP,
    ST_HOLD
  } rws_state_t;

endpackage

// ===== rtl/rws_if.sv =====
// ----------------------------------------------------------------------------
// rws_if
// Valid/ready channels of the region scroll block: command words and results.
// ----------------------------------------------------------------------------
interface rws_in_if import rws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [PIX_W-1:0]   pixel_data;

  modport source (output valid, func, pixel_x, pixel_y, pixel_data, input ready);
  modport sink   (input valid, func, pixel_x, pixel_y, pixel_data, output ready);
endinterface

interface rws_out_if import rws_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] read_data;
  logic             status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

// ===== rtl/region_wrap_scroll_top.sv =====
// ----------------------------------------------------------------------------
// region_wrap_scroll_top
// Frame store of rgb pixels with pixel write, pixel read and a wrapping
// one-pixel scroll of a configured rectangle.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  in_ch     in   valid / ready      func, pixel_x, pixel_y, pixel_data
//  out_ch    out  valid / ready      read_data, status
//  cfg       in   cfg_we (no wait)   cfg_index, cfg_data
//
//  write and error words are answered from idle, a pixel read passes through a read state;
//  a scroll step shifts each row (left/right) or column (up/down) of the rectangle by one,
//  wrapping the edge pixel, through the one read and one write port of the frame store
//  rst is synchronous; the frame store is not cleared and needs no sweep
//  a finished result sits in the output register while the next word is taken;
//  a second result behind a stalled output waits in a hold register and holds off the input
//
module region_wrap_scroll_top import rws_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  rws_in_if.sink           in_ch,
  rws_out_if.source        out_ch
);

  // address is {y, x}, row stride a power of two at or above MAX_WIDTH
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int AW      = XW + YW;
  localparam int DEPTH   = 1 << AW;
  localparam int CW      = (XW > YW) ? XW : YW;
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW      = $clog2(MAX_DIM + 1);
  localparam int CMPW    = (DW > CFG_W) ? DW : CFG_W;

  localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);
  localparam logic [CMPW-1:0] MAXH_C = CMPW'(MAX_HEIGHT);

  // configuration registers
  logic [CFG_W-1:0] image_width, image_height;
  logic [CFG_W-1:0] x_start, x_end, y_start, y_end;
  logic [DIR_W-1:0] direction;

  // sequencer
  rws_state_t state, state_next;

  // scroll walk: a line is a row for left/right, a column for up/down
  logic             horiz;       // left or right
  logic             fwd;         // left or up: walk toward higher positions
  logic [CW-1:0]    line;
  logic [CW-1:0]    line_last;
  logic [CW-1:0]    pos_f;       // position whose pixel wraps out
  logic [CW-1:0]    pos_g;       // position the wrapped pixel goes to
  logic [CW-1:0]    cur;         // position read this cycle
  logic [CW-1:0]    d_pos;       // position read last cycle
  logic             d_valid;     // read data of d_pos arrives this cycle
  logic             d_first;     // that read was the wrapping pixel
  logic [PIX_W-1:0] wrap;
  logic [CW-1:0]    dest;

  // results
  logic             out_valid;
  logic [PIX_W-1:0] out_data;
  logic             out_status;
  logic [PIX_W-1:0] hold_data;
  logic             hold_status;
  logic             res_fire;
  logic [PIX_W-1:0] res_data;
  logic             res_status;
  logic             load_ok;

  // input side
  logic             in_ready;
  logic             in_acc;
  logic [CMPW-1:0]  eff_w, eff_h;
  logic             pix_bad;
  logic             rect_bad;

  // frame store port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PIX_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [PIX_W-1:0] ram_rdata;

  function automatic logic [AW-1:0] pix_addr(logic [CW-1:0] x, logic [CW-1:0] y);
    return {YW'(y), XW'(x)};
  endfunction

  function automatic logic [AW-1:0] line_addr(logic h, logic [CW-1:0] ln,
                                              logic [CW-1:0] pos);
    return h ? pix_addr(pos, ln) : pix_addr(ln, pos);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      x_start      <= RST_X_START;
      x_end        <= RST_X_END;
      y_start      <= RST_Y_START;
      y_end        <= RST_Y_END;
      direction    <= RST_DIRECTION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_X_START:      x_start      <= cfg_data;
        REG_X_END:        x_end        <= cfg_data;
        REG_Y_START:      y_start      <= cfg_data;
        REG_Y_END:        y_end        <= cfg_data;
        REG_DIRECTION:    direction    <= cfg_data[DIR_W-1:0];
        default:          ;  // index beyond the list is ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checks on the incoming word
  // ---------------------------------------------------------------------------
  // image size in use is clipped to the store
  assign eff_w = (CMPW'(image_width) > MAXW_C) ? MAXW_C : CMPW'(image_width);
  assign eff_h = (CMPW'(image_height) > MAXH_C) ? MAXH_C : CMPW'(image_height);

  assign pix_bad = (CMPW'(in_ch.pixel_x) >= eff_w) || (CMPW'(in_ch.pixel_y) >= eff_h);

  // empty rectangle or one reaching past the image
  assign rect_bad = (x_start >= x_end) || (y_start >= y_end) ||
                    (CMPW'(x_end) > eff_w) || (CMPW'(y_end) > eff_h);

  assign in_acc  = in_ch.valid && in_ready;
  assign load_ok = !out_valid || out_ch.ready;

  // destination of the pixel arriving now: one step back along the walk
  assign dest = fwd ? (d_pos - CW'(1)) : (d_pos + CW'(1));

  // ---------------------------------------------------------------------------
  // sequencer and frame store control
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      d_valid <= 1'b0;
      d_first <= 1'b0;
    end else begin
      state   <= state_next;
      d_valid <= (state == ST_SCR_RD);
      d_first <= (state == ST_SCR_RD) && (cur == pos_f);
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_fire   = 1'b0;
    res_data   = '0;
    res_status = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = line_addr(horiz, line, dest);
    ram_wdata  = ram_rdata;
    ram_raddr  = line_addr(horiz, line, cur);
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = pix_addr(CW'(in_ch.pixel_x), CW'(in_ch.pixel_y));
        ram_waddr = pix_addr(CW'(in_ch.pixel_x), CW'(in_ch.pixel_y));
        ram_wdata = in_ch.pixel_data;
        if (in_acc) begin
          unique case (in_ch.func)
            FUNC_WRITE: begin
              res_fire   = 1'b1;
              res_status = pix_bad;
              ram_we     = !pix_bad;
            end
            FUNC_READ: begin
              if (pix_bad) begin
                res_fire   = 1'b1;
                res_status = 1'b1;
              end else begin
                state_next = ST_PIX_RD;
              end
            end
            FUNC_SCROLL: begin
              if (rect_bad) begin
                res_fire   = 1'b1;
                res_status = 1'b1;
              end else begin
                state_next = ST_SCR_RD;
              end
            end
            default: begin
              // unused function code
              res_fire   = 1'b1;
              res_status = 1'b1;
            end
          endcase
          if (res_fire && !load_ok) begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_PIX_RD: begin
        res_fire   = 1'b1;
        res_data   = ram_rdata;
        state_next = load_ok ? ST_IDLE : ST_HOLD;
      end
      ST_SCR_RD: begin
        // the wrapping pixel goes to the register, the rest shift back by one
        ram_we = d_valid && !d_first;
        if (cur == pos_g) begin
          state_next = ST_SCR_TAIL;
        end
      end
      ST_SCR_TAIL: begin
        ram_we     = !d_first;
        state_next = ST_SCR_WRAP;
      end
      ST_SCR_WRAP: begin
        ram_we    = 1'b1;
        ram_waddr = line_addr(horiz, line, pos_g);
        ram_wdata = wrap;
        if (line == line_last) begin
          res_fire   = 1'b1;
          state_next = load_ok ? ST_IDLE : ST_HOLD;
        end else begin
          state_next = ST_SCR_RD;
        end
      end
      ST_HOLD: begin
        res_fire   = 1'b1;
        res_data   = hold_data;
        res_status = hold_status;
        if (load_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // scroll walk registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    d_pos <= cur;
    if (state == ST_IDLE && in_acc && in_ch.func == FUNC_SCROLL && !rect_bad) begin
      horiz <= (direction == DIR_LEFT) || (direction == DIR_RIGHT);
      fwd   <= (direction == DIR_LEFT) || (direction == DIR_UP);
      if ((direction == DIR_LEFT) || (direction == DIR_RIGHT)) begin
        line      <= CW'(y_start);
        line_last <= CW'(y_end - CFG_W'(1));
      end else begin
        line      <= CW'(x_start);
        line_last <= CW'(x_end - CFG_W'(1));
      end
      unique case (direction)
        DIR_LEFT: begin
          pos_f <= CW'(x_start);
          pos_g <= CW'(x_end - CFG_W'(1));
          cur   <= CW'(x_start);
        end
        DIR_RIGHT: begin
          pos_f <= CW'(x_end - CFG_W'(1));
          pos_g <= CW'(x_start);
          cur   <= CW'(x_end - CFG_W'(1));
        end
        DIR_UP: begin
          pos_f <= CW'(y_start);
          pos_g <= CW'(y_end - CFG_W'(1));
          cur   <= CW'(y_start);
        end
        default: begin
          pos_f <= CW'(y_end - CFG_W'(1));
          pos_g <= CW'(y_start);
          cur   <= CW'(y_end - CFG_W'(1));
        end
      endcase
    end else if (state == ST_SCR_RD) begin
      cur <= fwd ? (cur + CW'(1)) : (cur - CW'(1));
    end else if (state == ST_SCR_WRAP && line != line_last) begin
      line <= line + CW'(1);
      cur  <= pos_f;
    end
    // the pixel that leaves the edge
    if ((state == ST_SCR_RD || state == ST_SCR_TAIL) && d_valid && d_first) begin
      wrap <= ram_rdata;
    end
  end

  // ---------------------------------------------------------------------------
  // output register and hold register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire && load_ok) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire && load_ok) begin
      out_data   <= res_data;
      out_status <= res_status;
    end
    if (res_fire && !load_ok && state != ST_HOLD) begin
      hold_data   <= res_data;
      hold_status <= res_status;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.read_data = out_data;
  assign out_ch.status    = out_status;

  // ---------------------------------------------------------------------------
  // frame store
  // ---------------------------------------------------------------------------
  rws_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a shift write never lands on the pixel being read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCR_RD && ram_we) |-> (ram_waddr != ram_raddr))
    else $error("scroll write and read hit the same pixel");

  // a result only waits in the hold register behind a full output register
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> out_valid)
    else $error("hold state with empty output register");

  // the last read of a line has its data in flight when the tail runs
  a_tail_data: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCR_TAIL) |-> d_valid)
    else $error("scroll tail without read data");

  // a valid scroll request starts the walk on the next cycle
  a_scroll_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.func == FUNC_SCROLL && !rect_bad) |=> (state == ST_SCR_RD))
    else $error("scroll step did not start");

endmodule

// ===== rtl/rws_ram.sv =====
// ----------------------------------------------------------------------------
// rws_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
